// File: design/lprb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprb_pkg: shared types and constants of the packet ring buffer
// Ring geometry, field widths, operation and status codes, parser phases and
// sequencer states.
// ----------------------------------------------------------------------------
package lprb_pkg;

    // Ring geometry
    localparam int BUF_DEPTH  = 4096;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int FILL_W     = $clog2(BUF_DEPTH + 1);
    localparam int CNT_W      = 12;
    localparam int LEN_W      = 16;

    // Framing limits
    localparam int MAX_PACKET    = 65535;
    localparam int HDR_BYTES     = 2;
    localparam int MAX_LEN_RESET = 1024;

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_READ    = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK     = 3'd0,
        STAT_FULL   = 3'd1,
        STAT_FRAME  = 3'd2,
        STAT_NOPKT  = 3'd3,
        STAT_RANGE  = 3'd4,
        STAT_LOCKED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_LOW  = 2'd0,
        PH_HIGH = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE      = 2'd0,
        CS_READ      = 2'd1,
        CS_HLEN_HI   = 2'd2,
        CS_HLEN_DONE = 2'd3
    } ctrl_state_t;

endpackage

// File: design/length_prefixed_packet_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring_buffer: byte ring with length-prefixed framing
// Stores received bytes in a ring memory, frames them into packets by their
// 16-bit little-endian length header, and serves reads and removes of the
// head packet.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                          | dir
//  ---------+------------------------------------------------+-----
//  command  | s_valid s_ready s_operation s_data_byte        | in
//           | s_read_offset                                  |
//  result   | m_valid m_ready m_status m_read_data           | out
//           | m_packets_ready m_free_space m_head_length     |
//  config   | cfg_valid cfg_ready cfg_data                   | in
//
// One command at a time. Receive, clear and rejected commands load the result
// on acceptance, a head read loads it from the registered ring read, and a
// remove that leaves packets behind first fetches the next head length header
// by two ring reads. Reset is synchronous and clears pointers, counts and flags
// at once; the ring itself gets no clearing pass. The result register frees the
// command side: a new command is taken while the previous beat is being taken.
// ----------------------------------------------------------------------------
module length_prefixed_packet_ring_buffer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // command channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [7:0]                    s_data_byte,
    input  logic [15:0]                   s_read_offset,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [7:0]                    m_read_data,
    output logic [lprb_pkg::CNT_W-1:0]    m_packets_ready,
    output logic [lprb_pkg::FILL_W-1:0]   m_free_space,
    output logic [lprb_pkg::LEN_W-1:0]    m_head_length,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [15:0]                   cfg_data
);

    localparam int ADDR_W = lprb_pkg::ADDR_W;
    localparam int FILL_W = lprb_pkg::FILL_W;
    localparam int CNT_W  = lprb_pkg::CNT_W;
    localparam int LEN_W  = lprb_pkg::LEN_W;

    // Ring memory
    logic [7:0] ring_mem [lprb_pkg::BUF_DEPTH];
    logic [7:0] ring_rdata_reg;
    logic [ADDR_W-1:0] mem_raddr;
    logic mem_we;

    // Control state
    lprb_pkg::ctrl_state_t state_reg, state_next;
    lprb_pkg::phase_t phase_reg, phase_next;
    logic [ADDR_W-1:0] head_ptr_reg, head_ptr_next;
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0] len_low_reg, len_low_next;
    logic [LEN_W-1:0] body_rem_reg, body_rem_next;
    logic [LEN_W-1:0] pkt_len_reg, pkt_len_next;
    logic [LEN_W-1:0] head_len_reg, head_len_next;
    logic removable_reg, removable_next;
    logic error_reg, error_next;
    logic [15:0] max_len_reg;
    logic [7:0] hl_low_reg;

    // Result register
    logic m_valid_reg, m_valid_next;
    logic [2:0] m_status_reg, m_status_next;
    logic [7:0] m_rdata_reg, m_rdata_next;
    logic [CNT_W-1:0] m_count_reg, m_count_next;
    logic [FILL_W-1:0] m_free_reg, m_free_next;
    logic [LEN_W-1:0] m_hlen_reg, m_hlen_next;
    logic out_load;

    logic accept;
    lprb_pkg::op_t op;
    logic [LEN_W-1:0] hdr_len;
    logic [LEN_W-1:0] limit;
    logic [FILL_W-1:0] rm_len;

    assign op        = lprb_pkg::op_t'(s_operation);
    assign s_ready   = (state_reg == lprb_pkg::CS_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign hdr_len = {s_data_byte, len_low_reg};
    assign limit   = (32'(max_len_reg) < lprb_pkg::MAX_PACKET)
                     ? max_len_reg : LEN_W'(lprb_pkg::MAX_PACKET);

    // Clamp the removed length to the bytes held
    always_comb begin
        if (32'(head_len_reg) > 32'(fill_reg)) begin
            rm_len = fill_reg;
        end else begin
            rm_len = FILL_W'(head_len_reg);
        end
    end

    // Next state of the sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lprb_pkg::CS_IDLE: begin
                if (accept) begin
                    if (op == lprb_pkg::OP_READ && count_reg != '0
                        && 32'(s_read_offset) < 32'(head_len_reg)) begin
                        state_next = lprb_pkg::CS_READ;
                    end else if (op == lprb_pkg::OP_REMOVE && count_reg > CNT_W'(1)
                                 && removable_reg) begin
                        state_next = lprb_pkg::CS_HLEN_HI;
                    end
                end
            end
            lprb_pkg::CS_READ:      state_next = lprb_pkg::CS_IDLE;
            lprb_pkg::CS_HLEN_HI:   state_next = lprb_pkg::CS_HLEN_DONE;
            lprb_pkg::CS_HLEN_DONE: state_next = lprb_pkg::CS_IDLE;
            default:                state_next = lprb_pkg::CS_IDLE;
        endcase
    end

    // Datapath, memory access and result
    always_comb begin
        phase_next     = phase_reg;
        head_ptr_next  = head_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        len_low_next   = len_low_reg;
        body_rem_next  = body_rem_reg;
        pkt_len_next   = pkt_len_reg;
        head_len_next  = head_len_reg;
        removable_next = removable_reg;
        error_next     = error_reg;
        mem_we         = 1'b0;
        mem_raddr      = head_ptr_reg + ADDR_W'(s_read_offset);
        out_load       = 1'b0;
        m_status_next  = m_status_reg;
        m_rdata_next   = m_rdata_reg;

        unique case (state_reg)
            lprb_pkg::CS_IDLE: begin
                if (op == lprb_pkg::OP_REMOVE) begin
                    mem_raddr = head_ptr_reg + ADDR_W'(rm_len);
                end
                if (accept) begin
                    m_status_next = lprb_pkg::STAT_OK;
                    m_rdata_next  = 8'd0;
                    out_load      = 1'b1;
                    unique case (op)
                        lprb_pkg::OP_RECEIVE: begin
                            if (error_reg) begin
                                m_status_next = lprb_pkg::STAT_LOCKED;
                            end else if (fill_reg == FILL_W'(lprb_pkg::BUF_DEPTH)) begin
                                m_status_next = lprb_pkg::STAT_FULL;
                            end else begin
                                // store the byte and advance the parser
                                mem_we      = 1'b1;
                                wr_ptr_next = wr_ptr_reg + ADDR_W'(1);
                                fill_next   = fill_reg + FILL_W'(1);
                                unique case (phase_reg)
                                    lprb_pkg::PH_LOW: begin
                                        len_low_next = s_data_byte;
                                        phase_next   = lprb_pkg::PH_HIGH;
                                    end
                                    lprb_pkg::PH_HIGH: begin
                                        if (32'(hdr_len) < lprb_pkg::HDR_BYTES
                                            || hdr_len > limit) begin
                                            error_next    = 1'b1;
                                            m_status_next = lprb_pkg::STAT_FRAME;
                                        end else if (32'(hdr_len) == lprb_pkg::HDR_BYTES) begin
                                            count_next = count_reg + CNT_W'(1);
                                            phase_next = lprb_pkg::PH_LOW;
                                            if (count_reg == '0) begin
                                                head_len_next = hdr_len;
                                            end
                                        end else begin
                                            body_rem_next = hdr_len
                                                - LEN_W'(lprb_pkg::HDR_BYTES);
                                            pkt_len_next  = hdr_len;
                                            phase_next    = lprb_pkg::PH_BODY;
                                        end
                                    end
                                    default: begin
                                        if (body_rem_reg <= LEN_W'(1)) begin
                                            body_rem_next = '0;
                                            count_next    = count_reg + CNT_W'(1);
                                            phase_next    = lprb_pkg::PH_LOW;
                                            if (count_reg == '0) begin
                                                head_len_next = pkt_len_reg;
                                            end
                                        end else begin
                                            body_rem_next = body_rem_reg - LEN_W'(1);
                                        end
                                    end
                                endcase
                            end
                        end
                        lprb_pkg::OP_READ: begin
                            if (count_reg == '0) begin
                                m_status_next = lprb_pkg::STAT_NOPKT;
                            end else if (32'(s_read_offset) >= 32'(head_len_reg)) begin
                                m_status_next = lprb_pkg::STAT_RANGE;
                            end else begin
                                // ring read under way; result follows
                                removable_next = 1'b1;
                                out_load       = 1'b0;
                            end
                        end
                        lprb_pkg::OP_REMOVE: begin
                            if (count_reg == '0 || !removable_reg) begin
                                m_status_next = lprb_pkg::STAT_NOPKT;
                            end else begin
                                // free the head packet
                                head_ptr_next  = head_ptr_reg + ADDR_W'(rm_len);
                                fill_next      = fill_reg - rm_len;
                                count_next     = count_reg - CNT_W'(1);
                                removable_next = 1'b0;
                                if (count_reg > CNT_W'(1)) begin
                                    out_load = 1'b0;
                                end
                            end
                        end
                        lprb_pkg::OP_CLEAR: begin
                            head_ptr_next  = '0;
                            wr_ptr_next    = '0;
                            fill_next      = '0;
                            count_next     = '0;
                            phase_next     = lprb_pkg::PH_LOW;
                            len_low_next   = '0;
                            body_rem_next  = '0;
                            removable_next = 1'b0;
                            error_next     = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            lprb_pkg::CS_READ: begin
                m_status_next = lprb_pkg::STAT_OK;
                m_rdata_next  = ring_rdata_reg;
                out_load      = 1'b1;
            end
            lprb_pkg::CS_HLEN_HI: begin
                mem_raddr = head_ptr_reg + ADDR_W'(1);
            end
            lprb_pkg::CS_HLEN_DONE: begin
                head_len_next = {ring_rdata_reg, hl_low_reg};
                m_status_next = lprb_pkg::STAT_OK;
                m_rdata_next  = 8'd0;
                out_load      = 1'b1;
            end
            default: ;
        endcase

        // result register load and drain
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
        m_count_next = count_next;
        m_free_next  = FILL_W'(lprb_pkg::BUF_DEPTH) - fill_next;
        m_hlen_next  = (count_next == '0) ? '0 : head_len_next;
    end

    // Ring write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wr_ptr_reg] <= s_data_byte;
        end
        ring_rdata_reg <= ring_mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lprb_pkg::CS_IDLE;
            phase_reg     <= lprb_pkg::PH_LOW;
            head_ptr_reg  <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            len_low_reg   <= '0;
            body_rem_reg  <= '0;
            pkt_len_reg   <= '0;
            head_len_reg  <= '0;
            removable_reg <= 1'b0;
            error_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            max_len_reg   <= 16'(lprb_pkg::MAX_LEN_RESET);
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            head_ptr_reg  <= head_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            len_low_reg   <= len_low_next;
            body_rem_reg  <= body_rem_next;
            pkt_len_reg   <= pkt_len_next;
            head_len_reg  <= head_len_next;
            removable_reg <= removable_next;
            error_reg     <= error_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                max_len_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == lprb_pkg::CS_HLEN_HI) begin
            hl_low_reg <= ring_rdata_reg;
        end
        if (out_load) begin
            m_status_reg <= m_status_next;
            m_rdata_reg  <= m_rdata_next;
            m_count_reg  <= m_count_next;
            m_free_reg   <= m_free_next;
            m_hlen_reg   <= m_hlen_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_read_data     = m_rdata_reg;
    assign m_packets_ready = m_count_reg;
    assign m_free_space    = m_free_reg;
    assign m_head_length   = m_hlen_reg;

endmodule

// File: dv/length_prefixed_packet_ring_buffer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring_buffer_test: self-checking bench of the ring
// Drives command beats from a queue, tracks the deframer state in a local
// model and checks every result beat field by field. The run covers a
// directed opener and random packet traffic under three length limits and
// varying back-pressure, including one long result-side stall.
// ----------------------------------------------------------------------------
module length_prefixed_packet_ring_buffer_test;

    localparam int BUF_DEPTH     = lprb_pkg::BUF_DEPTH;
    localparam int ADDR_W        = lprb_pkg::ADDR_W;
    localparam int FILL_W        = lprb_pkg::FILL_W;
    localparam int CNT_W         = lprb_pkg::CNT_W;
    localparam int LEN_W         = lprb_pkg::LEN_W;
    localparam int HDR_BYTES     = lprb_pkg::HDR_BYTES;
    localparam int MAX_LEN_RESET = lprb_pkg::MAX_LEN_RESET;

    typedef struct {
        lprb_pkg::op_t op;
        logic [7:0]    data;
        logic [15:0]   offset;
    } cmd_item_t;

    typedef struct {
        lprb_pkg::status_t  status;
        logic [7:0]         read_data;
        logic [CNT_W-1:0]   pkts;
        logic [FILL_W-1:0]  free;
        logic [LEN_W-1:0]   head_len;
    } result_t;

    // DUT input ports, all driven to known values from time zero
    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_operation = '0;
    logic [7:0]          s_data_byte = '0;
    logic [15:0]         s_read_offset = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [2:0]          m_status;
    logic [7:0]          m_read_data;
    logic [CNT_W-1:0]    m_packets_ready;
    logic [FILL_W-1:0]   m_free_space;
    logic [LEN_W-1:0]    m_head_length;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [15:0]         cfg_data = '0;

    length_prefixed_packet_ring_buffer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_data_byte     (s_data_byte),
        .s_read_offset   (s_read_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_read_data     (m_read_data),
        .m_packets_ready (m_packets_ready),
        .m_free_space    (m_free_space),
        .m_head_length   (m_head_length),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // Traffic control
    cmd_item_t pending_cmds [$];
    result_t   due_results [$];
    int        send_idle_pct = 16;
    int        recv_idle_pct = 63;
    bit        hold_arm = 1'b0;
    bit        hold_taken = 1'b0;
    int        hold_left = 0;

    // Bookkeeping
    int error_count = 0;
    int cmds_taken = 0;
    int beats_checked = 0;
    int cfg_writes = 0;
    int items_queued = 0;
    int status_seen [6] = '{default: 0};

    // Deframer model state
    logic [7:0]        ring_mem [BUF_DEPTH];
    logic [ADDR_W-1:0] rd_ptr;
    logic [ADDR_W-1:0] wr_ptr;
    logic [FILL_W-1:0] fill_lvl;
    lprb_pkg::phase_t  phase;
    logic [7:0]        len_lo;
    logic [15:0]       body_left;
    logic [CNT_W-1:0]  pkt_count;
    bit                read_armed;
    bit                frame_err;
    logic [15:0]       max_len;

    // Stimulus planning view: complete packets as the generator sees them
    int plan_q [$];
    int plan_fill = 0;
    bit plan_armed = 1'b0;
    int gen_max = MAX_LEN_RESET;

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------
    function automatic void clear_model();
        rd_ptr     = '0;
        wr_ptr     = '0;
        fill_lvl   = '0;
        phase      = lprb_pkg::PH_LOW;
        len_lo     = '0;
        body_left  = '0;
        pkt_count  = '0;
        read_armed = 1'b0;
        frame_err  = 1'b0;
    endfunction

    function automatic logic [15:0] head_len_now();
        logic [ADDR_W-1:0] hi_addr;
        hi_addr = rd_ptr + 1'b1;
        if (pkt_count == 0) return '0;
        return {ring_mem[hi_addr], ring_mem[rd_ptr]};
    endfunction

    function automatic result_t deframe_step(cmd_item_t c);
        result_t           r;
        int                plen;
        logic [ADDR_W-1:0] addr;
        r.status    = lprb_pkg::STAT_OK;
        r.read_data = '0;
        case (c.op)
            lprb_pkg::OP_RECEIVE: begin
                if (frame_err) begin
                    r.status = lprb_pkg::STAT_LOCKED;
                end else if (fill_lvl >= BUF_DEPTH) begin
                    r.status = lprb_pkg::STAT_FULL;
                end else begin
                    ring_mem[wr_ptr] = c.data;
                    wr_ptr   = wr_ptr + 1'b1;
                    fill_lvl = fill_lvl + 1'b1;
                    case (phase)
                        lprb_pkg::PH_LOW: begin
                            len_lo = c.data;
                            phase  = lprb_pkg::PH_HIGH;
                        end
                        lprb_pkg::PH_HIGH: begin
                            plen = {c.data, len_lo};
                            if (plen < HDR_BYTES || plen > max_len) begin
                                frame_err = 1'b1;
                                r.status  = lprb_pkg::STAT_FRAME;
                            end else if (plen == HDR_BYTES) begin
                                pkt_count = pkt_count + 1'b1;
                                phase     = lprb_pkg::PH_LOW;
                            end else begin
                                body_left = 16'(plen - HDR_BYTES);
                                phase     = lprb_pkg::PH_BODY;
                            end
                        end
                        default: begin
                            if (body_left != 0) body_left = body_left - 1'b1;
                            if (body_left == 0) begin
                                pkt_count = pkt_count + 1'b1;
                                phase     = lprb_pkg::PH_LOW;
                            end
                        end
                    endcase
                end
            end
            lprb_pkg::OP_READ: begin
                if (pkt_count == 0) begin
                    r.status = lprb_pkg::STAT_NOPKT;
                end else if (c.offset >= head_len_now()) begin
                    r.status = lprb_pkg::STAT_RANGE;
                end else begin
                    addr        = rd_ptr + ADDR_W'(c.offset);
                    r.read_data = ring_mem[addr];
                    read_armed  = 1'b1;
                end
            end
            lprb_pkg::OP_REMOVE: begin
                if (pkt_count == 0 || !read_armed) begin
                    r.status = lprb_pkg::STAT_NOPKT;
                end else begin
                    plen = head_len_now();
                    if (plen > fill_lvl) plen = fill_lvl;
                    rd_ptr     = rd_ptr + ADDR_W'(plen);
                    fill_lvl   = fill_lvl - FILL_W'(plen);
                    pkt_count  = pkt_count - 1'b1;
                    read_armed = 1'b0;
                end
            end
            default: clear_model();
        endcase
        r.pkts     = pkt_count;
        r.free     = FILL_W'(BUF_DEPTH - fill_lvl);
        r.head_len = head_len_now();
        return r;
    endfunction

    // Track register writes and accepted command beats
    always @(posedge aclk) begin : model_track
        cmd_item_t c;
        if (!aresetn) begin
            clear_model();
            max_len = 16'(MAX_LEN_RESET);
        end else begin
            if (cfg_valid && cfg_ready) max_len = cfg_data;
            if (s_valid && s_ready) begin
                c.op     = lprb_pkg::op_t'(s_operation);
                c.data   = s_data_byte;
                c.offset = s_read_offset;
                cmds_taken++;
                due_results.push_back(deframe_step(c));
            end
        end
    end

    // ------------------------------------------------------------------
    // Clock, driver, receiver, checker
    // ------------------------------------------------------------------
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Offer the next command beat; hold it until accepted
    always @(posedge aclk) begin : cmd_drive
        cmd_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                nxt = pending_cmds.pop_front();
                s_valid       <= 1'b1;
                s_operation   <= nxt.op;
                s_data_byte   <= nxt.data;
                s_read_offset <= nxt.offset;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result-side back-pressure, with one long hold-off when armed
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_arm && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= 400;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch on beat %0d: expected %0d, actual %0d",
                     $time, name, beats_checked, want, got);
        end
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_checked++;
            if (m_status < 6) status_seen[m_status]++;
            if (due_results.size() == 0) begin
                error_count++;
                $display("%0t: result beat with nothing expected, status %0d",
                         $time, m_status);
            end else begin
                want = due_results.pop_front();
                check_field("status", want.status, m_status);
                check_field("read_data", want.read_data, m_read_data);
                check_field("packets_ready", want.pkts, m_packets_ready);
                check_field("free_space", want.free, m_free_space);
                check_field("head_length", want.head_len, m_head_length);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_item(lprb_pkg::op_t op, logic [7:0] data, logic [15:0] offset);
        cmd_item_t c;
        c.op     = op;
        c.data   = data;
        c.offset = offset;
        pending_cmds.push_back(c);
        items_queued++;
    endtask

    task automatic emit_clear();
        add_item(lprb_pkg::OP_CLEAR, 8'($urandom), 16'($urandom));
        plan_q.delete();
        plan_fill  = 0;
        plan_armed = 1'b0;
    endtask

    // Read the head packet, mostly in range
    task automatic emit_read();
        int          len;
        logic [15:0] off;
        if (plan_q.size() == 0) begin
            add_item(lprb_pkg::OP_READ, 8'($urandom), 16'($urandom));
        end else begin
            len = plan_q[0];
            if ($urandom_range(99, 0) < 85) begin
                off        = 16'($urandom_range(len - 1, 0));
                plan_armed = 1'b1;
            end else if ($urandom_range(1, 0)) begin
                off = 16'($urandom_range(65535, len));
            end else begin
                off = 16'(len + $urandom_range(3, 0));
            end
            add_item(lprb_pkg::OP_READ, 8'($urandom), off);
        end
    endtask

    task automatic emit_remove();
        add_item(lprb_pkg::OP_REMOVE, 8'($urandom), 16'($urandom));
        if (plan_q.size() != 0 && plan_armed) begin
            plan_fill -= plan_q.pop_front();
            plan_armed = 1'b0;
        end
    endtask

    // Send one well-formed packet, optionally with head traffic in the middle
    task automatic emit_packet(int len, bit allow_cut);
        int         cut;
        logic [7:0] b;
        cut = (allow_cut && $urandom_range(99, 0) < 25) ? $urandom_range(len - 1, 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (i == cut) begin
                emit_read();
                if ($urandom_range(1, 0)) emit_remove();
            end
            b = (i == 0) ? len[7:0] : (i == 1) ? len[15:8] : 8'($urandom);
            add_item(lprb_pkg::OP_RECEIVE, b, 16'($urandom));
        end
        plan_q.push_back(len);
        plan_fill += len;
    endtask

    // Bad header or raw junk, always followed by a clear
    task automatic emit_noise();
        int bad;
        if ($urandom_range(1, 0)) begin
            if ($urandom_range(1, 0) || gen_max == 65535) bad = $urandom_range(1, 0);
            else bad = $urandom_range(65535, gen_max + 1);
            add_item(lprb_pkg::OP_RECEIVE, bad[7:0], 16'($urandom));
            add_item(lprb_pkg::OP_RECEIVE, bad[15:8], 16'($urandom));
            repeat ($urandom_range(3, 1))
                add_item(lprb_pkg::OP_RECEIVE, 8'($urandom), 16'($urandom));
            if (plan_q.size() != 0) begin
                emit_read();
                emit_remove();
            end
        end else begin
            repeat ($urandom_range(6, 2))
                add_item(lprb_pkg::op_t'($urandom_range(3, 0)), 8'($urandom),
                         16'($urandom));
        end
        emit_clear();
    endtask

    task automatic random_phase(int n_items);
        int target;
        int roll;
        int cap;
        int len;
        target = items_queued + n_items;
        while (items_queued < target) begin
            roll = $urandom_range(99, 0);
            if (roll < 42) begin
                cap = (gen_max < 48) ? gen_max : 48;
                if ($urandom_range(99, 0) < 10) cap = (gen_max < 600) ? gen_max : 600;
                // keep the packet within what is left of this phase
                if (cap > target - items_queued) cap = target - items_queued;
                if (cap < HDR_BYTES) cap = HDR_BYTES;
                len = $urandom_range(cap, HDR_BYTES);
                if (plan_fill + len > 3500) begin
                    emit_read();
                    emit_remove();
                end else begin
                    emit_packet(len, 1'b1);
                end
            end else if (roll < 66) begin
                emit_read();
            end else if (roll < 86) begin
                emit_remove();
            end else if (roll < 90) begin
                emit_clear();
            end else begin
                emit_noise();
            end
        end
        emit_clear();
    endtask

    task automatic directed_opener();
        add_item(lprb_pkg::OP_READ, 8'($urandom), 16'd0);
        add_item(lprb_pkg::OP_REMOVE, 8'($urandom), 16'($urandom));
        // header-only packet, then a five-byte one
        add_item(lprb_pkg::OP_RECEIVE, 8'h02, 16'($urandom));
        add_item(lprb_pkg::OP_RECEIVE, 8'h00, 16'($urandom));
        add_item(lprb_pkg::OP_RECEIVE, 8'h05, 16'($urandom));
        add_item(lprb_pkg::OP_RECEIVE, 8'h00, 16'($urandom));
        add_item(lprb_pkg::OP_RECEIVE, 8'h00, 16'($urandom));
        add_item(lprb_pkg::OP_RECEIVE, 8'hFF, 16'($urandom));
        add_item(lprb_pkg::OP_RECEIVE, 8'hAA, 16'($urandom));
        add_item(lprb_pkg::OP_REMOVE, 8'($urandom), 16'($urandom));
        add_item(lprb_pkg::OP_READ, 8'($urandom), 16'hFFFF);
        add_item(lprb_pkg::OP_READ, 8'($urandom), 16'd1);
        add_item(lprb_pkg::OP_REMOVE, 8'($urandom), 16'($urandom));
        add_item(lprb_pkg::OP_READ, 8'($urandom), 16'd4);
        add_item(lprb_pkg::OP_REMOVE, 8'($urandom), 16'($urandom));
        add_item(lprb_pkg::OP_RECEIVE, 8'h03, 16'($urandom));
        add_item(lprb_pkg::OP_RECEIVE, 8'h00, 16'($urandom));
        add_item(lprb_pkg::OP_RECEIVE, 8'h77, 16'($urandom));
        // length one above the reset limit locks the receiver
        add_item(lprb_pkg::OP_RECEIVE, 8'h01, 16'($urandom));
        add_item(lprb_pkg::OP_RECEIVE, 8'h04, 16'($urandom));
        add_item(lprb_pkg::OP_RECEIVE, 8'h5A, 16'($urandom));
        add_item(lprb_pkg::OP_READ, 8'($urandom), 16'd2);
        add_item(lprb_pkg::OP_REMOVE, 8'($urandom), 16'($urandom));
        emit_clear();
        // zero length
        add_item(lprb_pkg::OP_RECEIVE, 8'h00, 16'($urandom));
        add_item(lprb_pkg::OP_RECEIVE, 8'h00, 16'($urandom));
        emit_clear();
    endtask

    // Wait for several quiet edges in a row so the last beat is surely done
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (quiet < 4) begin
            @(posedge aclk);
            if (pending_cmds.size() != 0 || s_valid || due_results.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    task automatic write_max_len(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        gen_max    = value;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial begin : run_seq
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        directed_opener();
        wait_idle();
        write_max_len(16'd64);
        random_phase(340);
        wait_idle();

        send_idle_pct = 63;
        recv_idle_pct = 16;
        write_max_len(16'd2);
        random_phase(300);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_max_len(16'hFFFF);
        hold_arm = 1'b1;
        random_phase(380);
        wait_idle();

        repeat (10) @(posedge aclk);
        if (due_results.size() != 0) begin
            error_count++;
            $display("%0t: %0d predicted results never arrived", $time, due_results.size());
        end
        $display("Summary: %0d commands under %0d limit writes, %0d result beats checked",
                 cmds_taken, cfg_writes, beats_checked);
        $display("Statuses: ok %0d, full %0d, framing %0d, no packet %0d, range %0d, locked %0d",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (error_count == 0) begin
            $display("length_prefixed_packet_ring_buffer_test: done, clean");
        end else begin
            $display("length_prefixed_packet_ring_buffer_test: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("length_prefixed_packet_ring_buffer_test: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
design/lprb_pkg.sv
design/length_prefixed_packet_ring_buffer.sv
dv/length_prefixed_packet_ring_buffer_test.sv
